@@ src/assert_macros.svh @@
// Assertion macros shared by the range-sum segment tree RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ src/rsst_pkg.sv @@
// Shared types and constants for the range-sum segment tree
package rsst_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;
  localparam int CNT_W = 11;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // request kinds
  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // command queue between front and back (depth must be a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // classified command handed from front to back
  typedef struct packed {
    logic                    has_result;  // a result item is owed
    logic                    sum_en;      // range is non-empty after clipping
    logic [POS_W-1:0]        lo;
    logic [POS_W-1:0]        hi;
    logic                    set_en;      // position is inside the count
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

@@ src/rsst_if.sv @@
// Valid/ready channel interfaces for requests and results
interface rsst_in_if import rsst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [POS_W-1:0]        range_first;
  logic [POS_W-1:0]        range_second;
  logic [POS_W-1:0]        set_position;
  logic signed [VAL_W-1:0] set_value;

  modport source (
    output valid, req_type, range_first, range_second, set_position, set_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, range_first, range_second, set_position, set_value,
    output ready
  );
endinterface

interface rsst_out_if import rsst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] range_total;

  modport source (output valid, range_total, input ready);
  modport sink   (input valid, range_total, output ready);
endinterface

@@ src/rsst_fifo.sv @@
// Two-entry command queue between the front and back ends
module rsst_fifo import rsst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entries[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  // pointers wrap on their own since the depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEVER(a_fifo_overflow, push && full && !pop, "command queue overflow")
  `ASSERT_NEVER(a_fifo_underflow, pop && empty, "command queue underflow")

endmodule

@@ src/rsst_front.sv @@
// Front end: element count register, request intake and classification
module rsst_front import rsst_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  rsst_in_if.sink          in_chan,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             tree_ready,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_data
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_eff;
  logic [POS_W-1:0] lo;
  logic [POS_W-1:0] hi;
  logic             is_query;

  // element count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // count in use never exceeds the tree capacity
  assign n_eff = (32'(count_r) > 32'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : count_r;

  // order the range ends
  assign lo = (in_chan.range_first < in_chan.range_second) ?
              in_chan.range_first : in_chan.range_second;
  assign hi = (in_chan.range_first < in_chan.range_second) ?
              in_chan.range_second : in_chan.range_first;

  assign is_query = (in_chan.req_type == REQ_QUERY);

  // handshake: take an item once the tree is cleared and the queue has room
  assign in_chan.ready = tree_ready && !q_full;
  assign q_push        = in_chan.valid && in_chan.ready;

  // classify: clip the range and screen the set position
  always_comb begin
    q_data.has_result = is_query;
    q_data.sum_en     = is_query && (CNT_W'(lo) < n_eff);
    q_data.lo         = lo;
    q_data.hi         = (CNT_W'(hi) >= n_eff) ? POS_W'(n_eff - CNT_W'(1)) : hi;
    q_data.set_en     = (CNT_W'(in_chan.set_position) < n_eff);
    q_data.pos        = in_chan.set_position;
    q_data.value      = in_chan.set_value;
  end

endmodule

@@ src/rsst_back.sv @@
// Back end: tree memory, clearing pass, range-sum walk and point-update walk
module rsst_back import rsst_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd_data,
  output logic      cmd_pop,
  output logic      init_done,
  rsst_out_if.source out_chan
);

  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 1;

  localparam logic [AW-1:0] LEAF_BASE = AW'(MAX_ELEMENTS);
  localparam logic [AW-1:0] ROOT      = AW'(1);
  localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);
  localparam logic [PW-1:0] BASE_P    = PW'(MAX_ELEMENTS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QL,
    ST_QR,
    ST_QOUT,
    ST_ULEAF,
    ST_UWALK
  } state_t;

  state_t state_r, state_nxt;

  logic [SUM_W-1:0] mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [SUM_W-1:0] rd_data_r;

  cmd_t             cmd_r, cmd_nxt;
  logic [PW-1:0]    l_r, l_nxt;
  logic [PW-1:0]    r_r, r_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] v_r, v_nxt;
  logic [AW-1:0]    p_r, p_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic             qrd_r, qrd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_total_r, out_total_nxt;

  logic [PW-1:0]    r_dec;
  logic [AW-1:0]    leaf;
  logic [AW-1:0]    parent;
  logic [SUM_W-1:0] upd_sum;
  logic [SUM_W-1:0] set_ext;

  assign r_dec   = r_r - PW'(1);
  assign leaf    = LEAF_BASE + AW'(cmd_r.pos);
  assign parent  = p_r >> 1;
  assign upd_sum = v_r + rd_data_r;
  assign set_ext = {{(SUM_W-VAL_W){cmd_r.value[VAL_W-1]}}, cmd_r.value};

  assign init_done          = (state_r != ST_CLEAR);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.range_total = $signed(out_total_r);

  // tree memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    v_nxt         = v_r;
    p_nxt         = p_r;
    clr_nxt       = clr_r;
    qrd_nxt       = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_total_nxt = out_total_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    // a node read for the query lands in the cycle after it is issued
    if (qrd_r) begin
      acc_nxt = acc_r + rd_data_r;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_NODE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_data;
          acc_nxt = '0;
          l_nxt   = PW'(cmd_data.lo) + BASE_P;
          r_nxt   = PW'(cmd_data.hi) + BASE_P + PW'(1);
          if (cmd_data.sum_en) begin
            state_nxt = ST_QL;
          end else if (cmd_data.has_result) begin
            state_nxt = ST_QOUT;
          end else if (cmd_data.set_en) begin
            state_nxt = ST_ULEAF;
          end
        end
      end
      // left edge of the current level
      ST_QL: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            mem_re    = 1'b1;
            mem_raddr = l_r[AW-1:0];
            qrd_nxt   = 1'b1;
            l_nxt     = l_r + PW'(1);
          end
          state_nxt = ST_QR;
        end else begin
          state_nxt = ST_QOUT;
        end
      end
      // right edge, then climb one level
      ST_QR: begin
        if (r_r[0]) begin
          mem_re    = 1'b1;
          mem_raddr = r_dec[AW-1:0];
          qrd_nxt   = 1'b1;
        end
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = ST_QL;
      end
      ST_QOUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = acc_r;
          state_nxt     = cmd_r.set_en ? ST_ULEAF : ST_IDLE;
        end
      end
      // write the leaf and fetch its sibling
      ST_ULEAF: begin
        mem_we    = 1'b1;
        mem_waddr = leaf;
        mem_wdata = set_ext;
        v_nxt     = set_ext;
        p_nxt     = leaf;
        mem_re    = 1'b1;
        mem_raddr = leaf ^ AW'(1);
        state_nxt = ST_UWALK;
      end
      // parent = node + sibling, one level a cycle up to the root
      ST_UWALK: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = upd_sum;
        v_nxt     = upd_sum;
        p_nxt     = parent;
        if (parent == ROOT) begin
          state_nxt = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      qrd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      qrd_r       <= qrd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    acc_r       <= acc_nxt;
    v_r         <= v_nxt;
    p_r         <= p_nxt;
    out_total_r <= out_total_nxt;
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_no_node0_write, (mem_we && state_r != ST_CLEAR) |-> (mem_waddr != '0), "write to unused node zero")
  `ASSERT_CLK(a_no_pop_in_clear, (state_r == ST_CLEAR) |-> !cmd_pop, "command taken during clearing pass")
  `ASSERT_CLK(a_query_bounds, (state_r == ST_QL || state_r == ST_QR) |-> (l_r <= r_r), "query bounds crossed")
  `ASSERT_CLK(a_walk_has_sibling, (state_r == ST_UWALK) |-> $past(mem_re), "update step without sibling read")

endmodule

@@ src/range_sum_segment_tree.sv @@
// Range-sum segment tree top level: front end, command queue and tree back end
// After reset a clearing pass zeroes the tree, input not ready.
// Set item: the update walk climbs one tree level a cycle on one memory port.
// Query item: a range walk up the tree to the result, then the same update walk.
// A two-entry queue lets the next items be taken while the tree walk runs.
module range_sum_segment_tree import rsst_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  rsst_in_if.sink          in_chan,
  rsst_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;
  logic tree_ready;

  // intake and classification
  rsst_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .tree_ready (tree_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // decoupling queue
  rsst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // tree engine
  rsst_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd_data  (q_rdata),
    .cmd_pop   (q_pop),
    .init_done (tree_ready),
    .out_chan  (out_chan)
  );

endmodule
